### rtl/core/fcsg_pkg.sv
// Shared constants, register codes and word types for the filled circle span generator.
`timescale 1ns / 1ps

package fcsg_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CLIP_WIDTH   = 12;
    localparam int RADIUS_WIDTH = 13;

    localparam int CENTER_W    = 15;
    localparam int OFFSET_W    = 15;
    localparam int CLIP_POS_W  = CLIP_WIDTH;
    localparam int CLIP_SIZE_W = CLIP_WIDTH + 1;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_ADDR_W  = 3;

    localparam int ORG_W  = COORD_WIDTH + 1;
    localparam int BOX_W  = ORG_W + 1;
    localparam int ROW_W  = CLIP_WIDTH;
    localparam int SX_W   = RADIUS_WIDTH;
    localparam int SY_W   = RADIUS_WIDTH + 1;
    localparam int SW_W   = RADIUS_WIDTH + 1;
    localparam int DEC_W  = RADIUS_WIDTH + 3;
    localparam int NSPAN  = 4;
    localparam int SEL_W  = $clog2(NSPAN);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAN_X  = 3'd0,
        REG_PAN_Y  = 3'd1,
        REG_CLIP_X = 3'd2,
        REG_CLIP_Y = 3'd3,
        REG_CLIP_W = 3'd4,
        REG_CLIP_H = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_t;

    typedef struct packed {
        logic              reject;
        logic [ORG_W-1:0]  org_x;
        logic [ORG_W-1:0]  org_y;
        logic [ROW_W-1:0]  row_top;
        logic [ROW_W-1:0]  row_bottom;
        logic [SX_W-1:0]   step_x;
        logic [DEC_W-1:0]  decision;
    } start_res_t;

    typedef struct packed {
        logic [ORG_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [SW_W-1:0]  w;
    } span_ent_t;

    typedef struct packed {
        logic [NSPAN-1:0]            hit;
        span_ent_t [NSPAN-1:0]       spans;
        logic                        busy_next;
        logic [SX_W-1:0]             step_x;
        logic [SY_W-1:0]             step_y;
        logic [DEC_W-1:0]            decision;
    } step_res_t;

    typedef struct packed {
        logic [NSPAN-1:0]      mask;
        logic                  has_span;
        logic                  fin;
        span_ent_t [NSPAN-1:0] spans;
    } buf_load_t;

endpackage

### rtl/core/fcsg_start.sv
// Start setup: offset center, clip the bounding box and derive kept rows.
`timescale 1ns / 1ps

module fcsg_start
    import fcsg_pkg::*;
(
    input  logic signed [CENTER_W-1:0]  center_x,
    input  logic signed [CENTER_W-1:0]  center_y,
    input  logic        [SX_W-1:0]      radius,
    input  logic signed [OFFSET_W-1:0]  pan_x,
    input  logic signed [OFFSET_W-1:0]  pan_y,
    input  logic        [CLIP_POS_W-1:0]  clip_x,
    input  logic        [CLIP_POS_W-1:0]  clip_y,
    input  logic        [CLIP_SIZE_W-1:0] clip_w,
    input  logic        [CLIP_SIZE_W-1:0] clip_h,
    output start_res_t                  res
);

    localparam logic signed [BOX_W-1:0] CANVAS = BOX_W'(2 ** CLIP_WIDTH);
    localparam logic signed [BOX_W-1:0] ONE_B  = BOX_W'(1);

    logic signed [BOX_W-1:0] cen_x, cen_y, rad_s;
    logic signed [BOX_W-1:0] clip_l, clip_t, clip_r, clip_b, right_lim, bottom_lim;
    logic signed [BOX_W-1:0] lo_x, hi_x, lo_y, hi_y, lx, hx, ly, hy, hy_m1;

    always_comb
    begin
        cen_x  = BOX_W'(center_x) + BOX_W'(pan_x);
        cen_y  = BOX_W'(center_y) + BOX_W'(pan_y);
        rad_s  = $signed(BOX_W'(radius));
        clip_l = $signed(BOX_W'(clip_x));
        clip_t = $signed(BOX_W'(clip_y));
        clip_r = $signed(BOX_W'(clip_x) + BOX_W'(clip_w));
        clip_b = $signed(BOX_W'(clip_y) + BOX_W'(clip_h));
        // clip edges past the canvas are cut at the canvas size
        right_lim  = (clip_r < CANVAS) ? clip_r : CANVAS;
        bottom_lim = (clip_b < CANVAS) ? clip_b : CANVAS;

        lo_x = cen_x - rad_s;
        hi_x = cen_x + rad_s + ONE_B;
        lo_y = cen_y - rad_s;
        hi_y = cen_y + rad_s + ONE_B;

        lx = (lo_x > clip_l) ? lo_x : clip_l;
        hx = (hi_x < right_lim) ? hi_x : right_lim;
        ly = (lo_y > clip_t) ? lo_y : clip_t;
        hy = (hi_y < bottom_lim) ? hi_y : bottom_lim;
        hy_m1 = hy - ONE_B;

        res.reject     = (hx <= lx) || (hy <= ly);
        res.org_x      = cen_x[ORG_W-1:0];
        res.org_y      = cen_y[ORG_W-1:0];
        res.row_top    = ly[ROW_W-1:0];
        res.row_bottom = hy_m1[ROW_W-1:0];
        res.step_x     = radius;
        res.decision   = DEC_W'(1) - DEC_W'(radius);
    end

endmodule

### rtl/core/fcsg_step.sv
// One midpoint iteration: four mirrored span candidates and the next step state.
`timescale 1ns / 1ps

module fcsg_step
    import fcsg_pkg::*;
(
    input  logic [ORG_W-1:0] org_x,
    input  logic [ORG_W-1:0] org_y,
    input  logic [SX_W-1:0]  step_x,
    input  logic [SY_W-1:0]  step_y,
    input  logic [DEC_W-1:0] decision,
    input  logic [ROW_W-1:0] row_top,
    input  logic [ROW_W-1:0] row_bottom,
    output step_res_t        res
);

    localparam int YW = ORG_W + 1;
    localparam int NW = SY_W + 1;
    localparam logic signed [NW-1:0] ONE_N = NW'(1);

    logic signed [YW-1:0] ox, oy, cxv, cyv, top_s, bot_s;
    logic signed [YW-1:0] x_a, x_b, y0, y1, y2, y3;
    logic                 in0, in1, in2, in3, diag;
    logic [SW_W-1:0]      w_a, w_b;
    logic signed [NW-1:0] cy1, cx0, cx1, diff;
    logic signed [DEC_W-1:0] dec, dec_n;

    always_comb
    begin
        ox    = YW'($signed(org_x));
        oy    = YW'($signed(org_y));
        cxv   = $signed(YW'(step_x));
        cyv   = $signed(YW'(step_y));
        top_s = $signed(YW'(row_top));
        bot_s = $signed(YW'(row_bottom));

        x_a = ox - cxv;
        x_b = ox - cyv;
        y0  = oy + cyv;
        y1  = oy - cyv;
        y2  = oy + cxv;
        y3  = oy - cxv;
        w_a = {step_x, 1'b1};
        w_b = SW_W'({step_y, 1'b1});

        in0 = (y0 >= top_s) && (y0 <= bot_s);
        in1 = (y1 >= top_s) && (y1 <= bot_s);
        in2 = (y2 >= top_s) && (y2 <= bot_s);
        in3 = (y3 >= top_s) && (y3 <= bot_s);
        diag = ({1'b0, step_x} == step_y);

        // mirrored rows are dropped where they coincide
        res.hit[0] = in0;
        res.hit[1] = in1 && (step_y != '0);
        res.hit[2] = in2 && !diag;
        res.hit[3] = in3 && !diag && (step_x != '0);

        res.spans[0] = '{x: x_a[ORG_W-1:0], y: y0[ROW_W-1:0], w: w_a};
        res.spans[1] = '{x: x_a[ORG_W-1:0], y: y1[ROW_W-1:0], w: w_a};
        res.spans[2] = '{x: x_b[ORG_W-1:0], y: y2[ROW_W-1:0], w: w_b};
        res.spans[3] = '{x: x_b[ORG_W-1:0], y: y3[ROW_W-1:0], w: w_b};

        cy1  = $signed(NW'(step_y)) + ONE_N;
        cx0  = $signed(NW'(step_x));
        dec  = $signed(decision);
        if (dec < 0)
        begin
            cx1   = cx0;
            diff  = cy1;
            dec_n = dec + $signed(DEC_W'({cy1, 1'b1}));
        end
        else
        begin
            cx1   = cx0 - ONE_N;
            diff  = cy1 - cx1;
            dec_n = dec + $signed(DEC_W'({diff, 1'b1}));
        end

        res.busy_next = !(cx1 < cy1);
        res.step_x    = cx1[SX_W-1:0];
        res.step_y    = cy1[SY_W-1:0];
        res.decision  = dec_n;
    end

endmodule

### rtl/core/fcsg_span_buf.sv
// Result buffer: holds the words of one item and hands them out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module fcsg_span_buf
    import fcsg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  buf_load_t        load_data,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             span_valid,
    output logic [ORG_W-1:0] span_x,
    output logic [ROW_W-1:0] span_y,
    output logic [SW_W-1:0]  span_w,
    output logic             last,
    output logic             finished
);

    logic [NSPAN-1:0]      mask_reg, mask_next, rest;
    logic                  has_span_reg;
    logic                  fin_reg;
    span_ent_t [NSPAN-1:0] spans_reg;
    logic [SEL_W-1:0]      sel;
    logic                  pop;

    always_comb
    begin
        sel = '0;
        for (int i = NSPAN - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
        rest      = mask_reg & (mask_reg - NSPAN'(1));
        out_valid = (mask_reg != '0);
        last      = (rest == '0);
        pop       = out_valid && out_ready;
        can_load  = !out_valid || (last && out_ready);
        mask_next = load ? load_data.mask : (pop ? rest : mask_reg);

        finished   = fin_reg;
        span_valid = has_span_reg;
        span_x     = has_span_reg ? spans_reg[sel].x : '0;
        span_y     = has_span_reg ? spans_reg[sel].y : '0;
        span_w     = has_span_reg ? spans_reg[sel].w : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            has_span_reg <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (load)
            begin
                has_span_reg <= load_data.has_span;
                fin_reg      <= load_data.fin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            spans_reg <= load_data.spans;
        end
    end

endmodule

### rtl/core/filled_circle_span_generator_core.sv
// Top level of the filled circle span generator.
//
// Input channel (in_valid/in_ready): one word is a start (req_type = 0, center
// and radius) or a midpoint step (req_type = 1). Output channel
// (out_valid/out_ready): span words (span_x, span_y, span_w), with last on the
// final word of an input word and finished once no circle is active.
// A start gives one word with span_valid low; a step gives one to four span
// words, or one word with span_valid low if no circle is active or no span is in kept rows.
// Config: cfg_we writes cfg_wdata into the register picked by cfg_addr at once;
// write only while the block is idle.
// Order: an accepted word waits in the input register until the result buffer
// can take it; its first result is valid right after that load.
// Throughput: one input word per cycle when each yields one result and
// out_ready stays high; a step with several spans holds the result buffer
// until its words drain from the four-entry result buffer, one per cycle
// while out_ready is high. The input register takes the next word while
// results still drain.
// Reset clears the config registers (clip size to the full canvas), drops any
// active circle and empties both stages. When the receiver stalls the current
// result holds, the buffer stays full and in_ready falls once the input
// register is occupied.
`timescale 1ns / 1ps

module filled_circle_span_generator_core
    import fcsg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic signed [CENTER_W-1:0] center_x,
    input  logic signed [CENTER_W-1:0] center_y,
    input  logic [SX_W-1:0]            radius,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       span_valid,
    output logic signed [ORG_W-1:0]    span_x,
    output logic [ROW_W-1:0]           span_y,
    output logic [SW_W-1:0]            span_w,
    output logic                       last,
    output logic                       finished
);

    localparam logic [CLIP_SIZE_W-1:0] FULL_CLIP = CLIP_SIZE_W'(2 ** CLIP_WIDTH);

    // configuration
    logic signed [OFFSET_W-1:0] pan_x_reg, pan_y_reg;
    logic [CLIP_POS_W-1:0]      clip_x_reg, clip_y_reg;
    logic [CLIP_SIZE_W-1:0]     clip_w_reg, clip_h_reg;

    // input register
    logic                       in_vld_reg;
    logic                       req_type_reg;
    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [SX_W-1:0]            radius_reg;

    // circle state
    logic                       busy_reg;
    logic [ORG_W-1:0]           org_x_reg, org_y_reg;
    logic [SX_W-1:0]            step_x_reg;
    logic [SY_W-1:0]            step_y_reg;
    logic [DEC_W-1:0]           decision_reg;
    logic [ROW_W-1:0]           row_top_reg, row_bottom_reg;

    start_res_t                 start_res;
    step_res_t                  step_res;
    buf_load_t                  load_data;
    logic                       can_load, load;
    logic [ORG_W-1:0]           span_x_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_x_reg    <= '0;
            pan_y_reg    <= '0;
            clip_x_reg   <= '0;
            clip_y_reg   <= '0;
            clip_w_reg   <= FULL_CLIP;
            clip_h_reg   <= FULL_CLIP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PAN_X:  pan_x_reg  <= $signed(cfg_wdata[OFFSET_W-1:0]);
                REG_PAN_Y:  pan_y_reg  <= $signed(cfg_wdata[OFFSET_W-1:0]);
                REG_CLIP_X: clip_x_reg <= cfg_wdata[CLIP_POS_W-1:0];
                REG_CLIP_Y: clip_y_reg <= cfg_wdata[CLIP_POS_W-1:0];
                REG_CLIP_W: clip_w_reg <= cfg_wdata[CLIP_SIZE_W-1:0];
                REG_CLIP_H: clip_h_reg <= cfg_wdata[CLIP_SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    fcsg_start u_start (
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .radius   (radius_reg),
        .pan_x    (pan_x_reg),
        .pan_y    (pan_y_reg),
        .clip_x   (clip_x_reg),
        .clip_y   (clip_y_reg),
        .clip_w   (clip_w_reg),
        .clip_h   (clip_h_reg),
        .res      (start_res)
    );

    fcsg_step u_step (
        .org_x      (org_x_reg),
        .org_y      (org_y_reg),
        .step_x     (step_x_reg),
        .step_y     (step_y_reg),
        .decision   (decision_reg),
        .row_top    (row_top_reg),
        .row_bottom (row_bottom_reg),
        .res        (step_res)
    );

    always_comb
    begin
        load     = in_vld_reg && can_load;
        in_ready = !in_vld_reg || load;

        load_data.spans    = step_res.spans;
        load_data.mask     = NSPAN'(1);
        load_data.has_span = 1'b0;
        load_data.fin      = 1'b1;
        priority if (req_type_reg == REQ_START)
        begin
            load_data.fin = start_res.reject;
        end
        else if (busy_reg)
        begin
            load_data.fin = !step_res.busy_next;
            if (step_res.hit != '0)
            begin
                load_data.mask     = step_res.hit;
                load_data.has_span = 1'b1;
            end
        end
        else
        begin
            load_data.fin = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            row_top_reg    <= '0;
            row_bottom_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (load)
            begin
                in_vld_reg <= 1'b0;
            end

            if (load)
            begin
                if (req_type_reg == REQ_START)
                begin
                    busy_reg <= !start_res.reject;
                    if (!start_res.reject)
                    begin
                        org_x_reg      <= start_res.org_x;
                        org_y_reg      <= start_res.org_y;
                        step_x_reg     <= start_res.step_x;
                        step_y_reg     <= '0;
                        decision_reg   <= start_res.decision;
                        row_top_reg    <= start_res.row_top;
                        row_bottom_reg <= start_res.row_bottom;
                    end
                end
                else if (busy_reg)
                begin
                    busy_reg     <= step_res.busy_next;
                    step_x_reg   <= step_res.step_x;
                    step_y_reg   <= step_res.step_y;
                    decision_reg <= step_res.decision;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            center_x_reg <= center_x;
            center_y_reg <= center_y;
            radius_reg   <= radius;
        end
    end

    fcsg_span_buf u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_data  (load_data),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_valid (span_valid),
        .span_x     (span_x_raw),
        .span_y     (span_y),
        .span_w     (span_w),
        .last       (last),
        .finished   (finished)
    );

    assign span_x = $signed(span_x_raw);

    // spans always lie on kept rows; rows change only once the buffer drains
    a_span_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_valid |-> (span_y >= row_top_reg) && (span_y <= row_bottom_reg))
        else $error("span row outside kept rows");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> last && (span_w == '0) && (span_x == '0) && (span_y == '0))
        else $error("word without span is not a lone zero word");

    a_odd_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_valid |-> span_w[0])
        else $error("span width is even");

    a_busy_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, step_x_reg} >= step_y_reg))
        else $error("active circle past its diagonal");

endmodule

### tb/sv/tb.sv
// Self-checking bench for the filled circle span generator core.
`timescale 1ns / 1ps

module tb;
    import fcsg_pkg::*;

    // register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        req_t                  kind;
        logic [CENTER_W-1:0]   cx;
        logic [CENTER_W-1:0]   cy;
        logic [SX_W-1:0]       radius;
    } circle_req_t;

    typedef struct packed {
        logic              valid;
        logic [ORG_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic [SW_W-1:0]   w;
        logic              last;
        logic              fin;
    } span_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       req_type = 1'b0;
    logic signed [CENTER_W-1:0] center_x = '0;
    logic signed [CENTER_W-1:0] center_y = '0;
    logic [SX_W-1:0]            radius = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       span_valid;
    logic signed [ORG_W-1:0]    span_x;
    logic [ROW_W-1:0]           span_y;
    logic [SW_W-1:0]            span_w;
    logic                       last;
    logic                       finished;

    filled_circle_span_generator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_valid (span_valid),
        .span_x     (span_x),
        .span_y     (span_y),
        .span_w     (span_w),
        .last       (last),
        .finished   (finished)
    );

    circle_req_t req_queue[$];
    span_word_t  span_words_due[$];
    span_word_t  step_words[$];
    circle_req_t drv_next;
    span_word_t  mon_want;

    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int mismatches = 0;

    // register mirror
    longint m_off_x = 0, m_off_y = 0;
    longint m_clip_x = 0, m_clip_y = 0, m_clip_w = 4096, m_clip_h = 4096;

    // circle tracer state
    longint ctr_x = 0, ctr_y = 0, arc_x = 0, arc_y = 0, mid_err = 0;
    longint row_lo = 0, row_hi = 0;
    bit     live = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint least(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint most(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // number of midpoint steps until the arc closes
    function automatic int steps_to_close(input int r);
        int cx, cy, d, n;
        cx = r;
        cy = 0;
        d = 1 - r;
        n = 0;
        while (cx >= cy) begin
            cy++;
            if (d < 0) begin
                d += 2 * cy + 1;
            end else begin
                cx--;
                d += 2 * (cy - cx) + 1;
            end
            n++;
        end
        return n;
    endfunction

    function automatic logic [CENTER_W-1:0] clamp_center(input longint v);
        return CENTER_W'(most(-16384, least(16383, v)));
    endfunction

    task automatic keep_span(input longint x, input longint y, input longint w);
        span_word_t sw;
        if (y >= row_lo && y <= row_hi && step_words.size() < NSPAN) begin
            sw = '0;
            sw.valid = 1'b1;
            sw.x = x[ORG_W-1:0];
            sw.y = y[ROW_W-1:0];
            sw.w = w[SW_W-1:0];
            step_words.push_back(sw);
        end
    endtask

    // work out the words one accepted request produces
    task automatic trace_circle(input circle_req_t req);
        longint r, x, y, lx, hx, ly, hy, lim, cx, cy;
        bit done;
        span_word_t wd;
        lim = longint'(1) << CLIP_WIDTH;
        done = 1'b0;
        step_words.delete();
        if (req.kind == REQ_START) begin
            r = longint'(req.radius);
            x = longint'($signed(req.cx)) + m_off_x;
            y = longint'($signed(req.cy)) + m_off_y;
            lx = most(x - r, m_clip_x);
            hx = least(x + r + 1, least(m_clip_x + m_clip_w, lim));
            ly = most(y - r, m_clip_y);
            hy = least(y + r + 1, least(m_clip_y + m_clip_h, lim));
            step_words.push_back('0);
            if (hx <= lx || hy <= ly) begin
                live = 1'b0;
                done = 1'b1;
            end else begin
                ctr_x = x;
                ctr_y = y;
                arc_x = r;
                arc_y = 0;
                mid_err = 1 - r;
                row_lo = ly;
                row_hi = hy - 1;
                live = 1'b1;
            end
        end else if (!live) begin
            step_words.push_back('0);
            done = 1'b1;
        end else begin
            cx = arc_x;
            cy = arc_y;
            keep_span(ctr_x - cx, ctr_y + cy, 2 * cx + 1);
            if (cy != 0)
                keep_span(ctr_x - cx, ctr_y - cy, 2 * cx + 1);
            // octant rows; skip the mirror when it lands on the same row
            if (cx != cy) begin
                keep_span(ctr_x - cy, ctr_y + cx, 2 * cy + 1);
                if (cx != 0)
                    keep_span(ctr_x - cy, ctr_y - cx, 2 * cy + 1);
            end
            cy++;
            if (mid_err < 0) begin
                mid_err += 2 * cy + 1;
            end else begin
                cx--;
                mid_err += 2 * (cy - cx) + 1;
            end
            arc_x = cx;
            arc_y = cy;
            if (cx < cy) begin
                live = 1'b0;
                done = 1'b1;
            end
            if (step_words.size() == 0)
                step_words.push_back('0);
        end
        foreach (step_words[i]) begin
            wd = step_words[i];
            wd.fin = done;
            wd.last = (i == step_words.size() - 1);
            span_words_due.push_back(wd);
        end
    endtask

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic cmp_field(input string name, input logic [ORG_W-1:0] got,
                             input logic [ORG_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                trace_circle('{req_t'(req_type), center_x, center_y, radius});
            if (!in_valid || in_ready) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_next = req_queue.pop_front();
                    in_valid <= 1'b1;
                    req_type <= drv_next.kind;
                    center_x <= drv_next.cx;
                    center_y <= drv_next.cy;
                    radius <= drv_next.radius;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // span word monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (span_words_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected word x=%0d y=%0d w=%0d",
                                            span_x, span_y, span_w));
                end else begin
                    mon_want = span_words_due.pop_front();
                    cmp_field("span_valid", ORG_W'(span_valid), ORG_W'(mon_want.valid));
                    cmp_field("span_x", $unsigned(span_x), mon_want.x);
                    cmp_field("span_y", ORG_W'(span_y), ORG_W'(mon_want.y));
                    cmp_field("span_w", ORG_W'(span_w), ORG_W'(mon_want.w));
                    cmp_field("last", ORG_W'(last), ORG_W'(mon_want.last));
                    cmp_field("finished", ORG_W'(finished), ORG_W'(mon_want.fin));
                end
            end
            out_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PAN_X:  m_off_x = longint'($signed(val));
            REG_PAN_Y:  m_off_y = longint'($signed(val));
            REG_CLIP_X: m_clip_x = longint'(val[CLIP_POS_W-1:0]);
            REG_CLIP_Y: m_clip_y = longint'(val[CLIP_POS_W-1:0]);
            REG_CLIP_W: m_clip_w = longint'(val[CLIP_SIZE_W-1:0]);
            REG_CLIP_H: m_clip_h = longint'(val[CLIP_SIZE_W-1:0]);
            default: ;
        endcase
    endtask

    // junk in the unused upper bits of the clip registers must be dropped
    task automatic set_canvas(input int ox, input int oy, input int cx, input int cy,
                              input int cw, input int ch);
        write_reg(REG_PAN_X, CFG_DATA_W'(ox));
        write_reg(REG_PAN_Y, CFG_DATA_W'(oy));
        write_reg(REG_CLIP_X, {3'($urandom), cx[CLIP_POS_W-1:0]});
        write_reg(REG_CLIP_Y, {3'($urandom), cy[CLIP_POS_W-1:0]});
        write_reg(REG_CLIP_W, {2'($urandom), cw[CLIP_SIZE_W-1:0]});
        write_reg(REG_CLIP_H, {2'($urandom), ch[CLIP_SIZE_W-1:0]});
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_start(input logic [CENTER_W-1:0] x, input logic [CENTER_W-1:0] y,
                              input logic [SX_W-1:0] r);
        req_queue.push_back('{REQ_START, x, y, r});
    endtask

    // step words carry junk in the unused fields
    task automatic push_steps(input int n);
        for (int i = 0; i < n; i++)
            req_queue.push_back('{REQ_STEP, CENTER_W'($urandom), CENTER_W'($urandom),
                                  SX_W'($urandom)});
    endtask

    task automatic run_directed();
        push_steps(1);
        push_start(15'sd5, 15'sd5, 13'd0);
        push_steps(2);
        push_start(15'sd0, 15'sd0, 13'd1);
        push_steps(steps_to_close(1));
        push_start(15'sd100, 15'sd100, 13'd3);
        push_steps(steps_to_close(3));
        push_start(-15'sd16384, -15'sd16384, 13'd1);
        push_steps(1);
        push_start(15'sd16383, 15'sd16383, 13'd8191);
        push_start(-15'sd16384, -15'sd16384, 13'd8191);
        push_start(15'sd0, 15'sd0, 13'd8191);
        push_steps(2);
        push_start(15'sd2048, 15'sd2048, 13'd8191);
        push_steps(2);
        push_start(15'sd4095, 15'sd4095, 13'd0);
        push_steps(1);
        push_start(15'sd10, 15'sd4095, 13'd2);
        push_steps(steps_to_close(2));
    endtask

    // mostly whole circles near the clip window; some cut short, overrun or noise
    task automatic plan_circles(input int budget);
        int made, r, pick, n;
        longint tx, ty;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_steps(1);
                made += 1;
            end else if (pick < 16) begin
                push_start(CENTER_W'($urandom), CENTER_W'($urandom), SX_W'($urandom));
                n = $urandom_range(3);
                push_steps(n);
                made += 1 + n;
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    r = $urandom_range(20);
                else if (pick < 92)
                    r = $urandom_range(60, 21);
                else
                    r = $urandom_range(8191, 61);
                tx = m_clip_x - m_off_x - r - 2
                     + longint'($urandom_range(int'(m_clip_w) + 2 * r + 3));
                ty = m_clip_y - m_off_y - r - 2
                     + longint'($urandom_range(int'(m_clip_h) + 2 * r + 3));
                push_start(clamp_center(tx), clamp_center(ty), SX_W'(r));
                n = (r > 60) ? $urandom_range(12, 1) : steps_to_close(r);
                pick = $urandom_range(99);
                if (pick < 12 && n > 1)
                    n = $urandom_range(n - 1, 1);
                else if (pick < 24)
                    n += $urandom_range(2, 1);
                push_steps(n);
                made += 1 + n;
            end
        end
    endtask

    task automatic settle();
        while (req_queue.size() != 0 || in_valid || span_words_due.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        settle();

        set_canvas(0, 0, 0, 0, 4096, 4096);
        send_idle_pct = 87;
        plan_circles(45);
        settle();

        set_canvas(-12000, 12000, 100, 200, 64, 48);
        send_idle_pct = 0;
        ready_stall_pct = 87;
        plan_circles(45);
        settle();

        // clip window runs off the canvas edge
        set_canvas(3000, -3000, 4000, 4000, 8191, 8191);
        send_idle_pct = 34;
        ready_stall_pct = 34;
        plan_circles(45);
        settle();

        // zero width rejects every circle
        set_canvas(-16384, 16383, 10, 20, 0, 4096);
        send_idle_pct = 0;
        ready_stall_pct = 0;
        plan_circles(15);
        settle();

        set_canvas(int'($urandom_range(32767)) - 16384, int'($urandom_range(32767)) - 16384,
                   $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4096), $urandom_range(4096));
        plan_circles(45);
        settle();

        set_canvas(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                   $urandom_range(4095), $urandom_range(4095), 1, 1);
        send_idle_pct = 34;
        ready_stall_pct = 34;
        plan_circles(35);
        settle();

        set_canvas(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                   $urandom_range(2000), $urandom_range(2000),
                   $urandom_range(300, 1), 4096);
        send_idle_pct = 87;
        ready_stall_pct = 0;
        plan_circles(40);
        settle();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && span_words_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
